// ----- rtl/wlrs_pkg.sv -----
// shared types and constants of the wear-leveled record store
package wlrs_pkg;

  localparam int SLOT_W    = 8;
  localparam int WORD_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STAT_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 2'd1;

  localparam logic [WORD_W-1:0] MAGIC_RESET   = 16'h554B;
  localparam logic [WORD_W-1:0] VERSION_RESET = 16'h0002;
  localparam logic [STAT_W-1:0] ERASED_BYTE   = 8'hFF;

  localparam logic MODE_SAVE = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] rec_word_0;
    logic [WORD_W-1:0] rec_word_1;
    logic [WORD_W-1:0] rec_word_2;
    logic [WORD_W-1:0] rec_word_3;
  } req_t;

  typedef struct packed {
    logic              loaded;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] got_word_0;
    logic [WORD_W-1:0] got_word_1;
    logic [WORD_W-1:0] got_word_2;
    logic [WORD_W-1:0] got_word_3;
  } rsp_t;

endpackage

// ----- rtl/wlrs_if.sv -----
// handshake channel interfaces of the wear-leveled record store
interface wlrs_req_if import wlrs_pkg::*; ();
  logic valid;
  logic ready;
  req_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface wlrs_rsp_if import wlrs_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface wlrs_cfg_if import wlrs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/wear_leveled_record_store_top.sv -----
// wear-leveled record store: status ring walk, record save and load
//
// channels: req takes one item (mode 0 saves the four words, mode 1 loads the
// latest record), rsp returns exactly one item per request, cfg writes the
// magic code (index 0) and format version (index 1); cfg is always ready.
// all handshakes complete when valid and ready are high at a clock edge.
// each request walks the status ring in the status memory, one byte per
// cycle, starting from the last slot; the walk stops at the first break.
// a save then writes the record and status memories once the output register
// is free; a load reads the record memory, then checks the header once it is
// free. one request is in flight at a time and req is ready again from the
// edge that registers the result. a result waits in the output register while
// rsp is stalled; the next request may be taken and walked meanwhile, and its
// result holds until rsp drains.
// reset (rst, synchronous) restores the register defaults and marks every slot
// erased through per-slot valid bits, so no clearing pass is needed.
module wear_leveled_record_store_top import wlrs_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  wlrs_req_if.sink      req,
  wlrs_rsp_if.source    rsp,
  wlrs_cfg_if.sink      cfg
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_WRITE = 5'b00100,
    S_LREAD = 5'b01000,
    S_LCHK  = 5'b10000
  } state_t;

  state_t            state;
  logic [WORD_W-1:0] magic_word;
  logic [WORD_W-1:0] format_version;
  req_t              req_q;
  logic [SLOTS-1:0]  slot_vld;

  logic [AW-1:0]     rd_addr;
  logic              issue_first;
  logic              data_vld;
  logic              data_first;
  logic [AW-1:0]     data_slot;
  logic [STAT_W-1:0] stat_q;
  logic              stat_vld_q;
  logic [STAT_W-1:0] prev_byte;
  logic [STAT_W-1:0] last_byte;
  logic [AW-1:0]     w_idx;
  logic [STAT_W-1:0] pred_byte;

  logic [2*WORD_W-1:0] hdr_q;
  logic [4*WORD_W-1:0] body_q;
  logic                rec_vld_q;

  rsp_t rsp_q;
  logic rsp_valid_q;

  logic [STAT_W-1:0] status_mem [SLOTS];
  logic [2*WORD_W-1:0] hdr_mem [SLOTS];
  logic [4*WORD_W-1:0] body_mem [SLOTS];

  logic [STAT_W-1:0]   data_byte;
  logic [STAT_W-1:0]   expect_byte;
  logic [AW-1:0]       r_idx;
  logic                out_free;
  logic                save_we;
  logic [2*WORD_W-1:0] hdr_eff;
  logic [4*WORD_W-1:0] body_eff;
  logic                hit;
  state_t              act_state;

  assign data_byte   = stat_vld_q ? stat_q : ERASED_BYTE;
  assign expect_byte = prev_byte + 8'd1;
  assign r_idx       = (w_idx == '0) ? LAST : w_idx - AW'(1);
  assign out_free    = !rsp_valid_q || rsp.ready;
  assign save_we     = (state == S_WRITE) && out_free;
  assign hdr_eff     = rec_vld_q ? hdr_q : '1;
  assign body_eff    = rec_vld_q ? body_q : '1;
  assign hit         = (hdr_eff[WORD_W-1:0] == magic_word) &&
                       (hdr_eff[2*WORD_W-1:WORD_W] == format_version);
  assign act_state   = (req_q.mode == MODE_SAVE) ? S_WRITE : S_LREAD;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid_q;
  assign rsp.item  = rsp_q;

  // status ring memory
  always_ff @(posedge clk) begin
    if (save_we) begin
      status_mem[w_idx] <= pred_byte + 8'd1;
    end
    stat_q     <= status_mem[rd_addr];
    stat_vld_q <= slot_vld[rd_addr];
  end

  // record memories
  always_ff @(posedge clk) begin
    if (save_we) begin
      hdr_mem[w_idx]  <= {format_version, magic_word};
      body_mem[w_idx] <= {req_q.rec_word_3, req_q.rec_word_2,
                          req_q.rec_word_1, req_q.rec_word_0};
    end
    hdr_q     <= hdr_mem[r_idx];
    body_q    <= body_mem[r_idx];
    rec_vld_q <= slot_vld[r_idx];
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      req_q   <= req.item;
      rd_addr <= LAST;
    end else if (state == S_WALK) begin
      rd_addr   <= (rd_addr == LAST) ? '0 : rd_addr + AW'(1);
      data_slot <= rd_addr;
      if (data_vld) begin
        if (data_first) begin
          prev_byte <= data_byte;
          last_byte <= data_byte;
        end else if (data_byte != expect_byte) begin
          w_idx     <= data_slot;
          pred_byte <= prev_byte;
        end else if (data_slot == LAST) begin
          w_idx     <= '0;
          pred_byte <= last_byte;
        end else begin
          prev_byte <= data_byte;
        end
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      magic_word     <= MAGIC_RESET;
      format_version <= VERSION_RESET;
      slot_vld       <= '0;
      rsp_valid_q    <= 1'b0;
      data_vld       <= 1'b0;
      data_first     <= 1'b0;
      issue_first    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_MAGIC:   magic_word     <= cfg.data;
          REG_VERSION: format_version <= cfg.data;
          default: ;
        endcase
      end
      if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            issue_first <= 1'b1;
            data_vld    <= 1'b0;
            state       <= S_WALK;
          end
        end
        S_WALK: begin
          data_first  <= issue_first;
          issue_first <= 1'b0;
          data_vld    <= 1'b1;
          if (data_vld && !data_first) begin
            if (data_byte != expect_byte || data_slot == LAST) begin
              state <= act_state;
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            slot_vld[w_idx]  <= 1'b1;
            rsp_q.loaded     <= 1'b0;
            rsp_q.slot       <= SLOT_W'(w_idx);
            rsp_q.got_word_0 <= '0;
            rsp_q.got_word_1 <= '0;
            rsp_q.got_word_2 <= '0;
            rsp_q.got_word_3 <= '0;
            rsp_valid_q      <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_LREAD: begin
          state <= S_LCHK;
        end
        S_LCHK: begin
          if (out_free) begin
            rsp_q.loaded     <= hit;
            rsp_q.slot       <= SLOT_W'(r_idx);
            rsp_q.got_word_0 <= hit ? body_eff[WORD_W-1:0] : '0;
            rsp_q.got_word_1 <= hit ? body_eff[2*WORD_W-1:WORD_W] : '0;
            rsp_q.got_word_2 <= hit ? body_eff[3*WORD_W-1:2*WORD_W] : '0;
            rsp_q.got_word_3 <= hit ? body_eff[4*WORD_W-1:3*WORD_W] : '0;
            rsp_valid_q      <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/wlrs_chk.sv -----
// port-level assertions of the wear-leveled record store and their bind
module wlrs_chk import wlrs_pkg::*; #(
  parameter int SLOTS = 64
) (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_loaded,
  input logic [SLOT_W-1:0] rsp_slot,
  input logic [WORD_W-1:0] rsp_word_0,
  input logic [WORD_W-1:0] rsp_word_1,
  input logic [WORD_W-1:0] rsp_word_2,
  input logic [WORD_W-1:0] rsp_word_3
);

  localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(SLOTS);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_slot < SLOT_LIMIT)
    else $error("slot out of range");

  a_words_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_loaded |->
      rsp_word_0 == '0 && rsp_word_1 == '0 && rsp_word_2 == '0 && rsp_word_3 == '0)
    else $error("data words set without a loaded record");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while walk busy");

endmodule

bind wear_leveled_record_store_top wlrs_chk #(.SLOTS(SLOTS)) u_wlrs_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_loaded (rsp.item.loaded),
  .rsp_slot   (rsp.item.slot),
  .rsp_word_0 (rsp.item.got_word_0),
  .rsp_word_1 (rsp.item.got_word_1),
  .rsp_word_2 (rsp.item.got_word_2),
  .rsp_word_3 (rsp.item.got_word_3)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the wear-leveled record store with its own slot ring predictor
module testbench;
  import wlrs_pkg::*;

  localparam int SLOTS = 64;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int NUM_PHASES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic clk = 1'b0;
  logic rst;

  wlrs_req_if req_ch ();
  wlrs_rsp_if rsp_ch ();
  wlrs_cfg_if cfg_ch ();

  wear_leveled_record_store_top #(.SLOTS(SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source),
    .cfg (cfg_ch.sink)
  );

  always #4 clk = ~clk;

  logic [WORD_W-1:0]   magic_q;
  logic [WORD_W-1:0]   version_q;
  logic [31:0]         header_mem [SLOTS];
  logic [63:0]         body_mem [SLOTS];
  logic [STAT_W-1:0]   status_mem [SLOTS];

  req_t pending_requests [$];
  rsp_t predicted_results [$];

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int errors = 0;
  int n_saves = 0;
  int n_loads = 0;
  int n_hits = 0;
  int n_checked = 0;

  function automatic int ring_prev(int s);
    return (s == 0) ? SLOTS - 1 : s - 1;
  endfunction

  function automatic rsp_t walk_and_access(req_t r);
    rsp_t o;
    int w;
    int rd;
    bit found;
    logic [STAT_W-1:0] follow;
    o = '0;
    w = 0;
    found = 1'b0;
    for (int s = 0; s < SLOTS && !found; s++) begin
      follow = status_mem[ring_prev(s)] + 8'd1;
      if (follow != status_mem[s]) begin
        w = s;
        found = 1'b1;
      end
    end
    if (r.mode == MODE_SAVE) begin
      header_mem[w] = {version_q, magic_q};
      body_mem[w] = {r.rec_word_3, r.rec_word_2, r.rec_word_1, r.rec_word_0};
      status_mem[w] = status_mem[ring_prev(w)] + 8'd1;
      o.slot = w[SLOT_W-1:0];
      n_saves++;
    end else begin
      rd = ring_prev(w);
      o.slot = rd[SLOT_W-1:0];
      n_loads++;
      if (header_mem[rd] == {version_q, magic_q}) begin
        o.loaded = 1'b1;
        {o.got_word_3, o.got_word_2, o.got_word_1, o.got_word_0} = body_mem[rd];
        n_hits++;
      end
    end
    return o;
  endfunction

  function automatic req_t make_req(logic m, logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                                    logic [WORD_W-1:0] w2, logic [WORD_W-1:0] w3);
    req_t r;
    r.mode = m;
    r.rec_word_0 = w0;
    r.rec_word_1 = w1;
    r.rec_word_2 = w2;
    r.rec_word_3 = w3;
    return r;
  endfunction

  function automatic req_t random_req(int load_pct);
    return make_req(($urandom_range(99) < load_pct) ? MODE_LOAD : MODE_SAVE,
                    WORD_W'($urandom_range(16'hFFFF)), WORD_W'($urandom_range(16'hFFFF)),
                    WORD_W'($urandom_range(16'hFFFF)), WORD_W'($urandom_range(16'hFFFF)));
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predicted_results.push_back(walk_and_access(req_ch.item));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.item <= pending_requests.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result item with no request outstanding: %p", rsp_ch.item);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          check_field("loaded", WORD_W'(want.loaded), WORD_W'(rsp_ch.item.loaded));
          check_field("slot", WORD_W'(want.slot), WORD_W'(rsp_ch.item.slot));
          check_field("got_word_0", want.got_word_0, rsp_ch.item.got_word_0);
          check_field("got_word_1", want.got_word_1, rsp_ch.item.got_word_1);
          check_field("got_word_2", want.got_word_2, rsp_ch.item.got_word_2);
          check_field("got_word_3", want.got_word_3, rsp_ch.item.got_word_3);
          n_checked++;
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_MAGIC) begin
      magic_q = val;
    end else if (idx == REG_VERSION) begin
      version_q = val;
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || predicted_results.size() != 0);
  endtask

  initial begin
    logic [WORD_W-1:0] phase_magic [NUM_PHASES];
    logic [WORD_W-1:0] phase_version [NUM_PHASES];
    int idle_modes [4][2];

    req_ch.valid = 1'b0;
    req_ch.item = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MAGIC;
    cfg_ch.data = '0;
    rst = 1'b1;
    magic_q = MAGIC_RESET;
    version_q = VERSION_RESET;
    for (int s = 0; s < SLOTS; s++) begin
      header_mem[s] = '1;
      body_mem[s] = '1;
      status_mem[s] = ERASED_BYTE;
    end
    idle_modes = '{'{0, 0}, '{63, 0}, '{0, 63}, '{7, 7}};
    phase_magic = '{16'hFFFF, 16'h0000, WORD_W'($urandom_range(16'hFFFF)), MAGIC_RESET,
                    16'h0000, WORD_W'($urandom_range(16'hFFFF)), 16'hFFFF, MAGIC_RESET};
    phase_version = '{16'hFFFF, 16'h0000, WORD_W'($urandom_range(16'hFFFF)), VERSION_RESET,
                      16'hFFFF, WORD_W'($urandom_range(16'hFFFF)), 16'h0000, VERSION_RESET};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // erased ring under the reset settings
    pending_requests.push_back(make_req(MODE_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    drain();

    // erased header matches only when both registers are all ones
    write_reg(REG_MAGIC, 16'hFFFF);
    write_reg(REG_VERSION, 16'hFFFF);
    pending_requests.push_back(make_req(MODE_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_requests.push_back(make_req(MODE_SAVE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_requests.push_back(make_req(MODE_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    drain();

    write_reg(REG_MAGIC, MAGIC_RESET);
    write_reg(REG_VERSION, VERSION_RESET);
    pending_requests.push_back(make_req(MODE_LOAD, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
    pending_requests.push_back(make_req(MODE_SAVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_requests.push_back(make_req(MODE_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_requests.push_back(make_req(MODE_SAVE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_requests.push_back(make_req(MODE_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_requests.push_back(make_req(MODE_SAVE, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    pending_requests.push_back(make_req(MODE_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_requests.push_back(make_req(MODE_SAVE, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    pending_requests.push_back(make_req(MODE_SAVE, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE));
    pending_requests.push_back(make_req(MODE_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_requests.push_back(make_req(MODE_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    for (int i = 0; i < 6; i++) begin
      pending_requests.push_back(random_req(0));
    end
    pending_requests.push_back(make_req(MODE_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_MAGIC, phase_magic[p]);
      write_reg(REG_VERSION, phase_version[p]);
      if (p == 2) begin
        write_reg(REG_SPARE_2, WORD_W'($urandom_range(16'hFFFF)));
        write_reg(REG_SPARE_3, WORD_W'($urandom_range(16'hFFFF)));
      end
      @(negedge clk);
      send_idle_pct = idle_modes[p % 4][0];
      rsp_stall_pct = idle_modes[p % 4][1];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pending_requests.push_back(random_req((p % 2 == 0) ? 35 : 50));
      end
      drain();
    end

    repeat (SLOTS + 8) @(posedge clk);
    $display("run covered %0d saves and %0d loads (%0d found a valid record)",
             n_saves, n_loads, n_hits);
    $display("%0d results checked over %0d register settings incl. all-zero and all-one words",
             n_checked, NUM_PHASES + 2);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
